// File: hdl/flc_pkg.sv
// shared types and codes for the floppy controller nibble stepper
`timescale 1ns / 1ps

package flc_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_SWITCH = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // soft switch codes above the stepper phases
  localparam logic [3:0] SW_MOTOR_OFF  = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON   = 4'h9;
  localparam logic [3:0] SW_SELECT_0   = 4'hA;
  localparam logic [3:0] SW_SELECT_1   = 4'hB;
  localparam logic [3:0] SW_SHIFT      = 4'hC;
  localparam logic [3:0] SW_LOAD_LATCH = 4'hD;
  localparam logic [3:0] SW_READ_MODE  = 4'hE;
  localparam logic [3:0] SW_WRITE_MODE = 4'hF;

  // configuration register indexes
  localparam logic CFG_WRITE_PROTECT_0 = 1'b0;
  localparam logic CFG_WRITE_PROTECT_1 = 1'b1;

  localparam logic [7:0] PROTECT_FLAG = 8'h80;

  // input transaction
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  switch_index;
    logic [7:0]  value;
    logic        image_drive;
    logic [17:0] image_address;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       selected_drive;
    logic [5:0] track_now;
    logic       motor_running;
    logic       writing;
  } out_t;

  // memory request and latch control from the drive logic
  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic       latch_set;
  } ctrl_t;

  // result info carried while the store read completes
  typedef struct packed {
    logic       is_read;
    logic       load_latch;
    logic [7:0] rd_imm;
    logic       sel;
    logic [5:0] track;
    logic       motor;
    logic       writing;
  } stage_t;

endpackage

// File: hdl/flc_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps

module flc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one entry, read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/flc_ctrl.sv
// per drive stepper, motor and mode state with store address generation
`timescale 1ns / 1ps

module flc_ctrl #(
  parameter int TRACKS            = 35,
  parameter int NIBBLES_PER_TRACK = 6656,
  parameter int ADDR_W            = $clog2(2 * TRACKS * NIBBLES_PER_TRACK)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  flc_pkg::in_t        item_i,
  input  logic [7:0]          latch_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [0:0]          cfg_data_i,
  output flc_pkg::ctrl_t      ctl_o,
  output logic [ADDR_W-1:0]   addr_o,
  output flc_pkg::stage_t     stage_o
);

  localparam int unsigned DRIVE_NIBBLES = TRACKS * NIBBLES_PER_TRACK;
  localparam logic [ADDR_W-1:0] DRIVE_A  = ADDR_W'(DRIVE_NIBBLES);
  localparam logic [ADDR_W-1:0] NPT_A    = ADDR_W'(NIBBLES_PER_TRACK);
  localparam logic [6:0]        HALF_TOP = 7'(2 * (TRACKS - 1));
  localparam logic [6:0]        TRK_LIM  = 7'(TRACKS);
  localparam logic [5:0]        TRK_MAX  = 6'(TRACKS - 1);
  localparam logic [13:0]       NPT_W    = 14'(NIBBLES_PER_TRACK);

  logic [3:0]  pon_q [2], pon_d [2];
  logic [3:0]  pob_q [2], pob_d [2];
  logic [3:0]  pob2_q [2], pob2_d [2];
  logic [1:0]  last_q [2], last_d [2];
  logic [1:0]  prev_q [2], prev_d [2];
  logic [6:0]  half_q [2], half_d [2];
  logic [5:0]  trk_q [2], trk_d [2];
  logic [12:0] ofs_q [2], ofs_d [2];
  logic [1:0]  motor_q, motor_d;
  logic [1:0]  wflag_q, wflag_d;
  logic        sel_q, sel_d;
  logic [1:0]  wp_q;

  logic              d;
  logic [1:0]        p;
  logic              image_ok;
  logic [ADDR_W-1:0] img_addr;
  logic [ADDR_W-1:0] head_addr;
  logic [5:0]        t_cl;
  logic [13:0]       o_cl;
  logic [13:0]       o_inc;
  logic [13:0]       o_next;

  assign d = sel_q;
  assign p = item_i.switch_index[2:1];

  // store addresses for image ports and for the head position
  always_comb begin
    image_ok = 32'(item_i.image_address) < DRIVE_NIBBLES;
    img_addr = (item_i.image_drive ? DRIVE_A : '0) + ADDR_W'(item_i.image_address);
    t_cl     = ({1'b0, trk_q[d]} >= TRK_LIM) ? TRK_MAX : trk_q[d];
    o_cl     = ({1'b0, ofs_q[d]} >= NPT_W) ? 14'd0 : {1'b0, ofs_q[d]};
    o_inc    = o_cl + 14'd1;
    o_next   = (o_inc >= NPT_W) ? 14'd0 : o_inc;
    head_addr = (d ? DRIVE_A : '0) + ADDR_W'(t_cl) * NPT_A + ADDR_W'(o_cl);
  end

  assign addr_o = (item_i.opcode == flc_pkg::OP_SWITCH) ? head_addr : img_addr;

  // next state and memory request for one transaction
  always_comb begin
    logic [3:0] pob2_n;
    logic [3:0] pob_n;
    logic [3:0] pon_n;
    logic [6:0] h;
    logic [7:0] h_inc;
    pon_d   = pon_q;
    pob_d   = pob_q;
    pob2_d  = pob2_q;
    last_d  = last_q;
    prev_d  = prev_q;
    half_d  = half_q;
    trk_d   = trk_q;
    ofs_d   = ofs_q;
    motor_d = motor_q;
    wflag_d = wflag_q;
    sel_d   = sel_q;
    pob2_n  = pob2_q[d];
    pob_n   = pob_q[d];
    pon_n   = pon_q[d];
    h       = half_q[d];
    h_inc   = 8'd0;
    ctl_o.mem_en     = 1'b0;
    ctl_o.mem_we     = 1'b0;
    ctl_o.mem_wdata  = item_i.value;
    ctl_o.latch_set  = 1'b0;
    stage_o.is_read    = 1'b0;
    stage_o.load_latch = 1'b0;
    stage_o.rd_imm     = 8'd0;
    case (item_i.opcode)
      flc_pkg::OP_LOAD: begin
        ctl_o.mem_en = image_ok;
        ctl_o.mem_we = image_ok;
      end
      flc_pkg::OP_DUMP: begin
        ctl_o.mem_en    = image_ok;
        stage_o.is_read = image_ok;
      end
      flc_pkg::OP_SWITCH: begin
        if (item_i.switch_index inside {[4'd0:4'd7]}) begin
          // stepper phase: shift phase history, then move on a phase turning on
          pob2_n[prev_q[d]] = pob_q[d][prev_q[d]];
          pob_n[last_q[d]]  = pon_q[d][last_q[d]];
          pob2_d[d] = pob2_n;
          pob_d[d]  = pob_n;
          prev_d[d] = last_q[d];
          last_d[d] = p;
          if (!item_i.switch_index[0]) begin
            pon_n[p] = 1'b0;
          end else begin
            if (pob2_n[2'(p + 2'd1)]) begin
              h = (h == 7'd0) ? 7'd0 : h - 7'd1;
            end
            if (pob2_n[2'(p - 2'd1)]) begin
              h = (h >= HALF_TOP) ? HALF_TOP : h + 7'd1;
            end
            pon_n[p]  = 1'b1;
            half_d[d] = h;
            h_inc     = {1'b0, h} + 8'd1;
            trk_d[d]  = h_inc[6:1];
          end
          pon_d[d] = pon_n;
        end else begin
          case (item_i.switch_index)
            flc_pkg::SW_MOTOR_OFF: motor_d[d] = 1'b0;
            flc_pkg::SW_MOTOR_ON:  motor_d[d] = 1'b1;
            flc_pkg::SW_SELECT_0: begin
              motor_d[0] = motor_q[0] | motor_q[1];
              motor_d[1] = 1'b0;
              sel_d      = 1'b0;
            end
            flc_pkg::SW_SELECT_1: begin
              motor_d[1] = motor_q[0] | motor_q[1];
              motor_d[0] = 1'b0;
              sel_d      = 1'b1;
            end
            flc_pkg::SW_SHIFT: begin
              ctl_o.mem_en = 1'b1;
              if (wflag_q[d]) begin
                ctl_o.mem_we    = 1'b1;
                ctl_o.mem_wdata = latch_i;
                stage_o.rd_imm  = latch_i;
              end else begin
                stage_o.is_read    = 1'b1;
                stage_o.load_latch = 1'b1;
              end
              ofs_d[d] = o_next[12:0];
            end
            flc_pkg::SW_LOAD_LATCH: ctl_o.latch_set = 1'b1;
            flc_pkg::SW_READ_MODE: begin
              wflag_d[d]     = 1'b0;
              stage_o.rd_imm = wp_q[d] ? flc_pkg::PROTECT_FLAG : 8'd0;
            end
            flc_pkg::SW_WRITE_MODE: wflag_d[d] = 1'b1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    stage_o.sel     = sel_d;
    stage_o.track   = trk_d[sel_d];
    stage_o.motor   = motor_d[sel_d];
    stage_o.writing = wflag_d[sel_d];
  end

  // drive state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        pon_q[i]  <= '0;
        pob_q[i]  <= '0;
        pob2_q[i] <= '0;
        last_q[i] <= '0;
        prev_q[i] <= '0;
        half_q[i] <= '0;
        trk_q[i]  <= '0;
        ofs_q[i]  <= '0;
      end
      motor_q <= '0;
      wflag_q <= '0;
      sel_q   <= 1'b0;
    end else if (accept_i) begin
      pon_q   <= pon_d;
      pob_q   <= pob_d;
      pob2_q  <= pob2_d;
      last_q  <= last_d;
      prev_q  <= prev_d;
      half_q  <= half_d;
      trk_q   <= trk_d;
      ofs_q   <= ofs_d;
      motor_q <= motor_d;
      wflag_q <= wflag_d;
      sel_q   <= sel_d;
    end
  end

  // write protect configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == flc_pkg::CFG_WRITE_PROTECT_0) begin
        wp_q[0] <= cfg_data_i[0];
      end else begin
        wp_q[1] <= cfg_data_i[0];
      end
    end
  end

endmodule

// File: hdl/floppy_controller_nibble_stepper_core.sv
// top level of the two drive floppy controller with nibble store
`timescale 1ns / 1ps

// Two drive floppy controller core.
// Input channel: in_valid_i / in_stall_o carry one soft switch access,
// image nibble load or image nibble dump per transaction.
// Output channel: out_valid_o / out_stall_i return exactly one result per
// input transaction, in order.
// Configuration: cfg_we_i writes write protect flag cfg_index_i with
// cfg_data_i; write only while no transaction is in flight.
// Result path: the nibble store is read at the edge that accepts a
// transaction, which also loads the store read stage; the output register
// loads from that stage once it is free.
// Throughput: one transaction per cycle while in_stall_o is low, as each
// transaction makes at most one access to the single port nibble store.
// Reset clears drive state, drive select, data latch and write protect.
// The nibble store is not cleared and holds unknown data until written.
// When the receiver stalls, the output register holds its result, one more
// transaction can wait in the store read stage, and then in_stall_o rises.

module floppy_controller_nibble_stepper_core #(
  parameter int TRACKS            = 35,
  parameter int NIBBLES_PER_TRACK = 6656
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  flc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output flc_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [0:0]    cfg_data_i
);

  localparam int DEPTH  = 2 * TRACKS * NIBBLES_PER_TRACK;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              accept;
  logic              out_free;
  logic              s1_move;
  logic              s1_valid_q, s1_valid_d;
  flc_pkg::stage_t   s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  flc_pkg::out_t     out_q, out_d;
  logic [7:0]        latch_q, latch_d;
  logic [7:0]        latch_eff;
  logic [7:0]        ram_rdata;
  logic [ADDR_W-1:0] ram_addr;
  flc_pkg::ctrl_t    ctl;
  flc_pkg::stage_t   stage;

  // handshake: the store stage advances when the output register frees up
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // latch forwarding from a store read that completes this cycle
  assign latch_eff = (s1_valid_q && s1_q.load_latch) ? ram_rdata : latch_q;

  flc_ctrl #(
    .TRACKS            (TRACKS),
    .NIBBLES_PER_TRACK (NIBBLES_PER_TRACK),
    .ADDR_W            (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .latch_i     (latch_eff),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (ctl),
    .addr_o      (ram_addr),
    .stage_o     (stage)
  );

  flc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (accept && ctl.mem_en),
    .we_i    (ctl.mem_we),
    .addr_i  (ram_addr),
    .wdata_i (ctl.mem_wdata),
    .rdata_o (ram_rdata)
  );

  // store stage, output register and data latch next values
  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_d        = s1_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    latch_d     = latch_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_d       = stage;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d          = 1'b1;
      out_d.read_data      = s1_q.is_read ? ram_rdata : s1_q.rd_imm;
      out_d.selected_drive = s1_q.sel;
      out_d.track_now      = s1_q.track;
      out_d.motor_running  = s1_q.motor;
      out_d.writing        = s1_q.writing;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && ctl.latch_set) begin
      latch_d = in_data_i.value;
    end else if (s1_move && s1_q.load_latch) begin
      latch_d = ram_rdata;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      latch_q     <= 8'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      latch_q     <= latch_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/flc_drive_mon.sv
// scoreboard for the floppy controller core: predicts every result and compares it
`timescale 1ns / 1ps

module flc_drive_mon #(
  parameter int TRACKS            = 35,
  parameter int NIBBLES_PER_TRACK = 6656
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  flc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  flc_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [0:0]    cfg_data_i,
  output int            errors_o,
  output int            pending_o,
  output int            head_key_o,
  output logic          head_reads_o
);

  localparam int DRIVE    = TRACKS * NIBBLES_PER_TRACK;
  localparam int HALF_TOP = 2 * (TRACKS - 1);

  // predicted drive state
  logic [7:0] nib_mem [int];
  logic [3:0] ph_now [2];
  logic [3:0] ph_prev [2];
  logic [3:0] ph_prev2 [2];
  logic [1:0] last_ph [2];
  logic [1:0] prior_ph [2];
  logic [6:0] half_pos [2];
  logic [5:0] trk [2];
  logic [12:0] offs [2];
  logic       motor [2];
  logic       wmode [2];
  logic       wp [2];
  logic       sel;
  logic [7:0] latch;

  flc_pkg::out_t due_q [$];

  // store index under the head of drive d
  function automatic int head_index(input logic d);
    int t;
    int o;
    t = int'(trk[d]);
    o = int'(offs[d]);
    if (t >= TRACKS) t = TRACKS - 1;
    if (o >= NIBBLES_PER_TRACK) o = 0;
    return int'(d) * DRIVE + t * NIBBLES_PER_TRACK + o;
  endfunction

  // apply one transaction to the predicted state and form its result
  task automatic predict_access(input flc_pkg::in_t t, output flc_pkg::out_t r);
    logic       d;
    logic       n;
    logic [1:0] p;
    logic [1:0] up_nb;
    logic [1:0] dn_nb;
    int         h;
    int         a;
    int         o;
    logic [7:0] rd;
    rd = '0;
    d = sel;
    case (t.opcode)
      flc_pkg::OP_LOAD: begin
        if (t.image_address < DRIVE)
          nib_mem[int'(t.image_drive) * DRIVE + int'(t.image_address)] = t.value;
      end
      flc_pkg::OP_DUMP: begin
        if (t.image_address < DRIVE)
          rd = nib_mem[int'(t.image_drive) * DRIVE + int'(t.image_address)];
      end
      flc_pkg::OP_SWITCH: begin
        if (t.switch_index < flc_pkg::SW_MOTOR_OFF) begin
          // stepper phase: shift history, then move on a phase turning on
          p = t.switch_index[2:1];
          ph_prev2[d][prior_ph[d]] = ph_prev[d][prior_ph[d]];
          ph_prev[d][last_ph[d]] = ph_now[d][last_ph[d]];
          prior_ph[d] = last_ph[d];
          last_ph[d] = p;
          if (!t.switch_index[0]) begin
            ph_now[d][p] = 1'b0;
          end else begin
            up_nb = p + 2'd1;
            dn_nb = p - 2'd1;
            h = int'(half_pos[d]);
            if (ph_prev2[d][up_nb]) h = (h == 0) ? 0 : h - 1;
            if (ph_prev2[d][dn_nb]) h = (h >= HALF_TOP) ? HALF_TOP : h + 1;
            half_pos[d] = 7'(h);
            ph_now[d][p] = 1'b1;
            trk[d] = 6'((h + 1) / 2);
          end
        end else begin
          case (t.switch_index)
            flc_pkg::SW_MOTOR_OFF: motor[d] = 1'b0;
            flc_pkg::SW_MOTOR_ON:  motor[d] = 1'b1;
            flc_pkg::SW_SELECT_0, flc_pkg::SW_SELECT_1: begin
              n = (t.switch_index == flc_pkg::SW_SELECT_1);
              motor[n] = motor[n] | motor[~n];
              motor[~n] = 1'b0;
              sel = n;
            end
            flc_pkg::SW_SHIFT: begin
              a = head_index(d);
              if (wmode[d]) nib_mem[a] = latch;
              else latch = nib_mem[a];
              o = int'(offs[d]);
              if (o >= NIBBLES_PER_TRACK) o = 0;
              o = o + 1;
              if (o >= NIBBLES_PER_TRACK) o = 0;
              offs[d] = 13'(o);
              rd = latch;
            end
            flc_pkg::SW_LOAD_LATCH: latch = t.value;
            flc_pkg::SW_READ_MODE: begin
              wmode[d] = 1'b0;
              rd = wp[d] ? flc_pkg::PROTECT_FLAG : 8'h00;
            end
            default: wmode[d] = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    d = sel;
    r.read_data      = rd;
    r.selected_drive = d;
    r.track_now      = trk[d];
    r.motor_running  = motor[d];
    r.writing        = wmode[d];
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      errors_o++;
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    flc_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        ph_now[i] = '0;
        ph_prev[i] = '0;
        ph_prev2[i] = '0;
        last_ph[i] = '0;
        prior_ph[i] = '0;
        half_pos[i] = '0;
        trk[i] = '0;
        offs[i] = '0;
        motor[i] = 1'b0;
        wmode[i] = 1'b0;
        wp[i] = 1'b0;
      end
      sel = 1'b0;
      latch = '0;
      due_q.delete();
      pending_o = 0;
      head_key_o = 0;
      head_reads_o = 1'b1;
    end else begin
      // result transaction against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("result %h arrived with nothing expected", out_data_i);
          errors_o++;
        end else begin
          want = due_q.pop_front();
          check_field("read_data", want.read_data, out_data_i.read_data);
          check_field("selected_drive", 8'(want.selected_drive),
                      8'(out_data_i.selected_drive));
          check_field("track_now", 8'(want.track_now), 8'(out_data_i.track_now));
          check_field("motor_running", 8'(want.motor_running),
                      8'(out_data_i.motor_running));
          check_field("writing", 8'(want.writing), 8'(out_data_i.writing));
        end
      end
      if (cfg_we_i) wp[cfg_index_i] = cfg_data_i[0];
      if (in_valid_i && !in_stall_i) begin
        predict_access(in_data_i, want);
        due_q.push_back(want);
      end
      pending_o = due_q.size();
      head_key_o = head_index(sel);
      head_reads_o = !wmode[sel];
    end
  end

endmodule

// File: test/tb_floppy_controller_nibble_stepper_core.sv
// stimulus and verdict for the floppy controller core with its scoreboard alongside
`timescale 1ns / 1ps

module tb_floppy_controller_nibble_stepper_core;

  localparam int TRACKS            = 35;
  localparam int NIBBLES_PER_TRACK = 6656;
  localparam int DRIVE             = TRACKS * NIBBLES_PER_TRACK;
  localparam int ADDR_MAX          = 18'h3FFFF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd3;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  flc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  flc_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [0:0]    cfg_data = 1'b0;

  int         fail_count;
  int         due_count;
  int         head_key;
  logic       head_reads;

  int         idle_pct = 0;
  int         stall_pct = 0;
  int         sent = 0;
  logic       hold_req = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  logic [1:0] seek_ph = 2'd0;

  // store entries known to hold data
  bit         nib_written [int];
  int         nib_keys [$];

  always #2 clk = ~clk;

  floppy_controller_nibble_stepper_core #(
    .TRACKS(TRACKS),
    .NIBBLES_PER_TRACK(NIBBLES_PER_TRACK)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  flc_drive_mon #(
    .TRACKS(TRACKS),
    .NIBBLES_PER_TRACK(NIBBLES_PER_TRACK)
  ) drive_mon (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_i(in_stall),
    .in_data_i(in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i(out_data),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .errors_o(fail_count),
    .pending_o(due_count),
    .head_key_o(head_key),
    .head_reads_o(head_reads)
  );

  // result side: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic flc_pkg::in_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(flc_pkg::in_t)-1:0];
  endfunction

  // offer one transaction, with random idle cycles first; returns on a falling edge
  task automatic send_access(input flc_pkg::in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = t;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic poke_switch(input logic [3:0] sw);
    flc_pkg::in_t t;
    t = rand_item();
    t.opcode = flc_pkg::OP_SWITCH;
    t.switch_index = sw;
    send_access(t);
  endtask

  function automatic void mark_written(input int key);
    if (!nib_written.exists(key)) begin
      nib_written[key] = 1'b1;
      nib_keys.push_back(key);
    end
  endfunction

  task automatic load_nibble(input logic drv, input int addr, input logic [7:0] v);
    flc_pkg::in_t t;
    t = rand_item();
    t.opcode = flc_pkg::OP_LOAD;
    t.image_drive = drv;
    t.image_address = 18'(addr);
    t.value = v;
    send_access(t);
    if (addr < DRIVE) mark_written(int'(drv) * DRIVE + addr);
  endtask

  task automatic dump_nibble(input logic drv, input int addr);
    flc_pkg::in_t t;
    t = rand_item();
    t.opcode = flc_pkg::OP_DUMP;
    t.image_drive = drv;
    t.image_address = 18'(addr);
    send_access(t);
  endtask

  // shift at the head; a read of a never written nibble is preceded by a load
  task automatic shift_head();
    int   key;
    logic reads;
    key = head_key;
    reads = head_reads;
    if (reads && !nib_written.exists(key))
      load_nibble(1'(key / DRIVE), key % DRIVE, 8'($urandom));
    poke_switch(flc_pkg::SW_SHIFT);
    if (!reads) mark_written(key);
  endtask

  // seek by pairs: next phase on, then the old one off
  task automatic seek(input logic [1:0] dir, input int pairs);
    logic [1:0] nxt;
    repeat (pairs) begin
      nxt = seek_ph + dir;
      poke_switch({1'b0, nxt, 1'b1});
      poke_switch({1'b0, seek_ph, 1'b0});
      seek_ph = nxt;
    end
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
  endtask

  task automatic write_protect(input logic idx, input logic v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one random access or short access sequence
  task automatic random_burst();
    int           r;
    int           key;
    logic [3:0]   sw;
    flc_pkg::in_t t;
    r = $urandom_range(99);
    if (r < 30) begin
      seek($urandom_range(1) ? STEP_UP : STEP_DOWN, $urandom_range(1, 6));
    end else if (r < 50) begin
      if ($urandom_range(1)) poke_switch(flc_pkg::SW_LOAD_LATCH);
      if ($urandom_range(2) == 0)
        poke_switch($urandom_range(1) ? flc_pkg::SW_WRITE_MODE : flc_pkg::SW_READ_MODE);
      repeat ($urandom_range(1, 4)) shift_head();
    end else if (r < 62) begin
      if ($urandom_range(7) == 0)
        load_nibble(1'($urandom_range(1)), $urandom_range(DRIVE, ADDR_MAX), 8'($urandom));
      else
        load_nibble(1'($urandom_range(1)), $urandom_range(DRIVE - 1), 8'($urandom));
    end else if (r < 74) begin
      if (nib_keys.size() == 0 || $urandom_range(5) == 0) begin
        dump_nibble(1'($urandom_range(1)), $urandom_range(DRIVE, ADDR_MAX));
      end else begin
        key = nib_keys[$urandom_range(nib_keys.size() - 1)];
        dump_nibble(1'(key / DRIVE), key % DRIVE);
      end
    end else if (r < 84) begin
      poke_switch(4'($urandom_range(flc_pkg::SW_MOTOR_OFF, flc_pkg::SW_SELECT_1)));
    end else if (r < 93) begin
      sw = 4'($urandom_range(15));
      if (sw == flc_pkg::SW_SHIFT) shift_head();
      else poke_switch(sw);
    end else begin
      t = rand_item();
      t.opcode = OP_UNUSED;
      send_access(t);
    end
  endtask

  task automatic random_phase(input int items, input int idle, input int stall);
    int goal;
    idle_pct = idle;
    stall_pct = stall;
    goal = sent + items;
    while (sent < goal) random_burst();
  endtask

  // main sequence
  initial begin
    flc_pkg::in_t t;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    write_protect(flc_pkg::CFG_WRITE_PROTECT_0, 1'b1);
    write_protect(flc_pkg::CFG_WRITE_PROTECT_1, 1'b0);

    // directed: protect flag, image port extremes, unused opcode, drive swap, stepping
    poke_switch(flc_pkg::SW_READ_MODE);
    load_nibble(1'b0, 0, 8'hFF);
    load_nibble(1'b1, DRIVE - 1, 8'h00);
    load_nibble(1'b0, ADDR_MAX, 8'h5A);
    dump_nibble(1'b0, 0);
    dump_nibble(1'b1, DRIVE - 1);
    dump_nibble(1'b1, DRIVE);
    dump_nibble(1'b0, ADDR_MAX);
    send_access('1);
    poke_switch(flc_pkg::SW_MOTOR_ON);
    poke_switch(flc_pkg::SW_SELECT_1);
    poke_switch(flc_pkg::SW_READ_MODE);
    poke_switch(flc_pkg::SW_WRITE_MODE);
    t = rand_item();
    t.opcode = flc_pkg::OP_SWITCH;
    t.switch_index = flc_pkg::SW_LOAD_LATCH;
    t.value = 8'h00;
    send_access(t);
    shift_head();
    poke_switch(flc_pkg::SW_SELECT_0);
    poke_switch(flc_pkg::SW_MOTOR_OFF);
    shift_head();
    seek(STEP_UP, 2);
    seek(STEP_DOWN, 3);
    drain();

    // climb to the half track ceiling, then random phases with different idling
    seek(STEP_UP, 72);
    random_phase(45, 0, 0);
    drain();
    write_protect(flc_pkg::CFG_WRITE_PROTECT_0, 1'b0);
    write_protect(flc_pkg::CFG_WRITE_PROTECT_1, 1'b0);
    random_phase(45, 74, 0);
    drain();
    write_protect(flc_pkg::CFG_WRITE_PROTECT_0, 1'b1);
    write_protect(flc_pkg::CFG_WRITE_PROTECT_1, 1'b1);
    random_phase(45, 0, 74);
    drain();
    write_protect(flc_pkg::CFG_WRITE_PROTECT_0, 1'b0);
    write_protect(flc_pkg::CFG_WRITE_PROTECT_1, 1'b1);
    random_phase(45, 18, 18);
    drain();

    // back pressure: long hold-off on the result side while items keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_req = ~hold_req;
    random_phase(20, 0, 0);
    drain();
    write_protect(flc_pkg::CFG_WRITE_PROTECT_0, 1'b1);
    write_protect(flc_pkg::CFG_WRITE_PROTECT_1, 1'b0);
    random_phase(30, 18, 18);
    drain();

    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hdl/flc_pkg.sv
hdl/flc_ram.sv
hdl/flc_ctrl.sv
hdl/floppy_controller_nibble_stepper_core.sv
test/flc_drive_mon.sv
test/tb_floppy_controller_nibble_stepper_core.sv
